@@ rtl/stt_pkg.sv @@
// shared constants, command and result codes for the software timer table
// controller/datapath handshake structs; no dependencies
package stt_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(NUM_TIMERS);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	localparam logic [1:0] KIND_CREATE  = 2'd0;
	localparam logic [1:0] KIND_DESTROY = 2'd1;
	localparam logic [1:0] KIND_FIRE    = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture item, restart scan
		logic step;       // move to next slot (create/destroy search)
		logic reply;      // finish create/destroy, write reply
		logic tick_step;  // update current slot for a tick
		logic flush;      // push the held fire as the last result
	} stt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       out_free;
		logic       slot_hit;
		logic       last_slot;
		logic       pend_valid;
		logic       fire_room;
	} stt_stat_t;

endpackage

@@ rtl/stt_ctrl.sv @@
// sequencer for the timer table: walks the slots for each item
// depends on stt_pkg
module stt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stt_pkg::stt_stat_t stat,
	output stt_pkg::stt_cmd_t  cmd
);
	import stt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   need_out;

	assign in_stall = (state_q != ST_IDLE);
	assign need_out = stat.slot_hit && stat.fire_room && stat.pend_valid;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.cmd == CMD_CREATE || stat.cmd == CMD_DESTROY) begin
					if (stat.slot_hit || stat.last_slot) begin
						if (stat.out_free) begin
							cmd.reply = 1'b1;
							state_d   = ST_IDLE;
						end
					end else begin
						cmd.step = 1'b1;
					end
				end else if (stat.cmd == CMD_TICK) begin
					// a second fire pushes the held one, so wait for room
					if (!need_out || stat.out_free) begin
						cmd.tick_step = 1'b1;
						if (stat.last_slot)
							state_d = ST_FLUSH;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cmd) <= 1)
		else $error("more than one datapath command");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SCAN)
		else $error("load did not start a scan");
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> stat.pend_valid && stat.out_free)
		else $error("flush without held fire or output room");

endmodule

@@ rtl/stt_datapath.sv @@
// slot storage, scan index, held fire and output register of the timer table
// depends on stt_pkg
module stt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         command,
	input  logic [31:0]        timeout_ms,
	input  logic               periodic,
	input  logic [15:0]        handler_tag,
	input  logic [15:0]        timer_id,
	input  logic [15:0]        elapsed_ms,
	input  stt_pkg::stt_cmd_t  cmd,
	output stt_pkg::stt_stat_t stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [1:0]         status,
	output logic [15:0]        result_id,
	output logic [15:0]        fired_tag,
	output logic               last
);
	import stt_pkg::*;

	logic [1:0]       cmd_q;
	logic [31:0]      timeout_q;
	logic             per_q;
	logic [15:0]      tag_q;
	logic [15:0]      tid_q;
	logic [15:0]      elapsed_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      next_id_q;
	logic [CNT_W-1:0] fire_cnt_q;
	logic             pend_valid_q;
	logic [15:0]      pend_id_q;
	logic [15:0]      pend_tag_q;

	logic [NUM_TIMERS-1:0] valid_q;
	logic                  per_mem  [NUM_TIMERS];
	logic [15:0]           id_mem   [NUM_TIMERS];
	logic [31:0]           period_mem [NUM_TIMERS];
	logic [31:0]           rem_mem  [NUM_TIMERS];
	logic [15:0]           tag_mem  [NUM_TIMERS];

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [1:0]       status_q;
	logic [15:0]      result_id_q;
	logic [15:0]      fired_tag_q;
	logic             last_q;

	logic        cur_valid;
	logic [31:0] cur_rem;
	logic        expired;
	logic        slot_hit;
	logic        out_free;
	logic        fire_room;
	logic        tick_fire;
	logic        push;

	assign cur_valid = valid_q[idx_q];
	assign cur_rem   = rem_mem[idx_q];
	assign expired   = cur_rem <= {16'd0, elapsed_q};
	assign out_free  = !out_valid_q || !out_stall;
	assign fire_room = fire_cnt_q < CNT_W'(MAX_RESULTS);
	assign tick_fire = cur_valid && expired;

	always_comb begin
		case (cmd_q)
			CMD_CREATE:  slot_hit = !cur_valid;
			CMD_DESTROY: slot_hit = cur_valid && (id_mem[idx_q] == tid_q);
			CMD_TICK:    slot_hit = tick_fire;
			default:     slot_hit = 1'b0;
		endcase
	end

	assign stat.cmd        = cmd_q;
	assign stat.out_free   = out_free;
	assign stat.slot_hit   = slot_hit;
	assign stat.last_slot  = (idx_q == IDX_W'(NUM_TIMERS - 1));
	assign stat.pend_valid = pend_valid_q;
	assign stat.fire_room  = fire_room;

	assign push = cmd.reply || cmd.flush
		|| (cmd.tick_step && tick_fire && fire_room && pend_valid_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			next_id_q    <= '0;
			idx_q        <= '0;
			fire_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				fire_cnt_q   <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.step || cmd.tick_step)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.reply && slot_hit) begin
				if (cmd_q == CMD_CREATE) begin
					valid_q[idx_q] <= 1'b1;
					next_id_q      <= next_id_q + 16'd1;
				end else begin
					valid_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.tick_step && tick_fire) begin
				if (!per_mem[idx_q])
					valid_q[idx_q] <= 1'b0;
				if (fire_room) begin
					fire_cnt_q   <= fire_cnt_q + CNT_W'(1);
					pend_valid_q <= 1'b1;
				end
			end
			if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= command;
			timeout_q <= timeout_ms;
			per_q     <= periodic;
			tag_q     <= handler_tag;
			tid_q     <= timer_id;
			elapsed_q <= elapsed_ms;
		end
		if (cmd.reply && slot_hit && cmd_q == CMD_CREATE) begin
			per_mem[idx_q]    <= per_q;
			id_mem[idx_q]     <= next_id_q;
			period_mem[idx_q] <= timeout_q;
			rem_mem[idx_q]    <= timeout_q;
			tag_mem[idx_q]    <= tag_q;
		end
		if (cmd.tick_step && cur_valid) begin
			if (expired)
				rem_mem[idx_q] <= period_mem[idx_q];
			else
				rem_mem[idx_q] <= cur_rem - {16'd0, elapsed_q};
		end
		if (cmd.tick_step && tick_fire && fire_room) begin
			pend_id_q  <= id_mem[idx_q];
			pend_tag_q <= tag_mem[idx_q];
		end
		if (cmd.reply) begin
			fired_tag_q <= '0;
			last_q      <= 1'b1;
			if (cmd_q == CMD_CREATE) begin
				kind_q      <= KIND_CREATE;
				status_q    <= slot_hit ? STAT_OK : STAT_FULL;
				result_id_q <= slot_hit ? next_id_q : 16'd0;
			end else begin
				kind_q      <= KIND_DESTROY;
				status_q    <= slot_hit ? STAT_OK : STAT_NOT_FOUND;
				result_id_q <= tid_q;
			end
		end else if (push) begin
			// held fire goes out; last only when the scan is over
			kind_q      <= KIND_FIRE;
			status_q    <= STAT_OK;
			result_id_q <= pend_id_q;
			fired_tag_q <= pend_tag_q;
			last_q      <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign result_id = result_id_q;
	assign fired_tag = fired_tag_q;
	assign last      = last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over an unaccepted one");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("fire count beyond limit");
	a_pend_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> fire_cnt_q != '0)
		else $error("held fire without a counted fire");

endmodule

@@ rtl/software_timer_table.sv @@
// top level of the software timer table: controller plus slot datapath
// depends on stt_pkg, stt_ctrl, stt_datapath
//
// One item is handled at a time; the slot table is walked one slot per
// cycle unless it waits on a stalled output. A create visits the slots up
// to and including the lowest free slot (all NUM_TIMERS when the table is
// full), a destroy those up to the matching one (all NUM_TIMERS when not
// found), and a tick always visits all NUM_TIMERS slots, then sends its
// held final fire if there is one. Results leave through a one-entry output
// register; while it is stalled the scan waits at the next fire or reply.
// Command 3 is taken and gives no result.
module software_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] timeout_ms,
	input  logic        periodic,
	input  logic [15:0] handler_tag,
	input  logic [15:0] timer_id,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [1:0]  status,
	output logic [15:0] result_id,
	output logic [15:0] fired_tag,
	output logic        last
);
	import stt_pkg::*;

	stt_cmd_t  cmd;
	stt_stat_t stat;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	stt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.timeout_ms  (timeout_ms),
		.periodic    (periodic),
		.handler_tag (handler_tag),
		.timer_id    (timer_id),
		.elapsed_ms  (elapsed_ms),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.status      (status),
		.result_id   (result_id),
		.fired_tag   (fired_tag),
		.last        (last)
	);

endmodule
